FILE: rtl/aes128_block_decrypt_macros.svh
// ---------------------------------------------------------------------------
// aes128_block_decrypt assertion macros
// shared property forms for the block decrypt checks
// ---------------------------------------------------------------------------
`ifndef AES128_BLOCK_DECRYPT_MACROS_SVH
`define AES128_BLOCK_DECRYPT_MACROS_SVH

// overlapping implication, checked outside reset
`define AESD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("aesd check failed");

// next-cycle implication, checked outside reset
`define AESD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aesd check failed");

`endif

FILE: rtl/aesd_pkg.sv
// ---------------------------------------------------------------------------
// aesd_pkg
// types, byte tables and round functions for aes-128 decryption
// ---------------------------------------------------------------------------
package aesd_pkg;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } in_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } out_t;

  typedef enum logic [0:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_t;

  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] GF_POLY   = 8'h1b;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] REV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8 * (4 * c + r) -: 8] = REV_BOX[s[127 - 8 * (4 * ((c - r + 4) % 4) + r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int i = 0; i < 4; i++) begin
      a[i]  = col[31 - 8 * i -: 8];
      x2[i] = xtime(a[i]);
      x4[i] = xtime(x2[i]);
      x8[i] = xtime(x4[i]);
      m9[i] = x8[i] ^ a[i];
      mb[i] = x8[i] ^ x2[i] ^ a[i];
      md[i] = x8[i] ^ x4[i] ^ a[i];
      me[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      t[127 - 32 * c -: 32] = inv_mix_col(s[127 - 32 * c -: 32]);
    end
    return t;
  endfunction

  // one step of the key schedule: next round key from the previous one
  function automatic logic [127:0] key_step(input logic [127:0] w, input logic [7:0] rcon);
    logic [31:0] t;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    t  = {w[23:0], w[31:24]};
    t  = {FWD_BOX[t[31:24]] ^ rcon, FWD_BOX[t[23:16]], FWD_BOX[t[15:8]], FWD_BOX[t[7:0]]};
    w0 = w[127:96] ^ t;
    w1 = w[95:64] ^ w0;
    w2 = w[63:32] ^ w1;
    w3 = w[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

FILE: rtl/aesd_round_cell.sv
// ---------------------------------------------------------------------------
// aesd_round_cell
// one inverse round: unshift, unsubstitute, add key, optional unmix
// ---------------------------------------------------------------------------
module aesd_round_cell import aesd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         valid_in,
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  input  logic         mix_en,
  output logic         valid_out,
  output logic [127:0] state_out
);

  logic [127:0] keyed;

  assign keyed = inv_shift_sub(state_in) ^ round_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    state_out <= mix_en ? inv_mix(keyed) : keyed;
  end

endmodule

FILE: rtl/aesd_key_sched.sv
// ---------------------------------------------------------------------------
// aesd_key_sched
// key registers and round key expansion, one round key per cycle
// ---------------------------------------------------------------------------
module aesd_key_sched import aesd_pkg::*; #(
  parameter int NUM_ROUNDS = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data,
  output logic         expanding,
  output logic [127:0] round_keys [NUM_ROUNDS + 1]
);

  localparam int CntW = $clog2(NUM_ROUNDS + 1);

  logic [63:0]     key_high;
  logic [63:0]     key_low;
  logic [CntW-1:0] cnt;
  logic [7:0]      rcon;
  logic [127:0]    work;
  logic [127:0]    new_key;
  logic [127:0]    step_key;

  always_comb begin
    unique case (cfg_idx_t'(cfg_index))
      CFG_KEY_HIGH: new_key = {cfg_data, key_low};
      CFG_KEY_LOW:  new_key = {key_high, cfg_data};
      default:      new_key = {key_high, key_low};
    endcase
  end

  assign step_key = key_step(work, rcon);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high      <= '0;
      key_low       <= '0;
      work          <= '0;
      round_keys[0] <= '0;
      cnt           <= CntW'(1);
      rcon          <= RCON_INIT;
      expanding     <= 1'b1;
    end else if (cfg_valid) begin
      key_high      <= new_key[127:64];
      key_low       <= new_key[63:0];
      work          <= new_key;
      round_keys[0] <= new_key;
      cnt           <= CntW'(1);
      rcon          <= RCON_INIT;
      expanding     <= 1'b1;
    end else if (expanding) begin
      round_keys[cnt] <= step_key;
      work            <= step_key;
      rcon            <= xtime(rcon);
      cnt             <= cnt + CntW'(1);
      if (cnt == CntW'(NUM_ROUNDS)) begin
        expanding <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/aes128_block_decrypt.sv
// ---------------------------------------------------------------------------
// aes128_block_decrypt
// pipelined aes-128 block decryption taking, while busy is low, one block per cycle
// ---------------------------------------------------------------------------
// A block is taken whenever start is high and busy is low, one per cycle with
// no gaps. Its plaintext comes out on dout after the pipeline, flagged by
// done for exactly one cycle; the receiver cannot hold results off, so it
// must take every done transfer. The pipeline is one input key-add register
// followed by one cell per round, each cell doing a full inverse round per
// cycle. Key writes are always accepted (cfg_ready is tied high) and must
// only be made while no block is in flight; each write, and reset itself,
// starts a key expansion that computes one round key per cycle, so busy
// stays high until all NUM_ROUNDS = 10 round keys are written, and no block
// is taken meanwhile.
// ---------------------------------------------------------------------------
`include "aes128_block_decrypt_macros.svh"

module aes128_block_decrypt import aesd_pkg::*; #(
  parameter int NUM_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         din,
  output logic        done,
  output out_t        dout,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  logic [127:0] round_keys [NUM_ROUNDS + 1];
  logic         expanding;

  // valid and state per stage; stage 0 is the initial key add
  logic         stage_valid [NUM_ROUNDS + 1];
  logic [127:0] stage_state [NUM_ROUNDS + 1];

  assign cfg_ready = 1'b1;
  assign busy      = expanding;

  aesd_key_sched #(
    .NUM_ROUNDS (NUM_ROUNDS)
  ) u_key_sched (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .expanding  (expanding),
    .round_keys (round_keys)
  );

  // input transfer: add the last round key
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else begin
      stage_valid[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    stage_state[0] <= din ^ round_keys[NUM_ROUNDS];
  end

  // row of round cells, the last one skips the column unmix
  for (genvar j = 1; j <= NUM_ROUNDS; j++) begin : g_cell
    aesd_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (stage_valid[j - 1]),
      .state_in  (stage_state[j - 1]),
      .round_key (round_keys[NUM_ROUNDS - j]),
      .mix_en    (j != NUM_ROUNDS),
      .valid_out (stage_valid[j]),
      .state_out (stage_state[j])
    );
  end

  assign done = stage_valid[NUM_ROUNDS];
  assign dout = out_t'(stage_state[NUM_ROUNDS]);

  // an accepted block leaves after the full row of cells
  `AESD_ASSERT_IMP(a_latency, clk, rst, start && !busy, ##(NUM_ROUNDS + 1) done)
  // a key write always restarts the expansion
  `AESD_ASSERT_NXT(a_cfg_expand, clk, rst, cfg_valid && cfg_ready, busy)
  // outside reset, a rise of busy only comes from a key write
  `AESD_ASSERT_IMP(a_busy_cause, clk, rst, $rose(busy), $past(cfg_valid && cfg_ready))

endmodule
